[rtl/sequential_list_engine_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sequential list engine
// Shared concurrent assertion forms used by the list engine RTL.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_ENGINE_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sequential list engine: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sequential list engine: assertion failed");

`endif

[rtl/sle_pkg.sv]
// ----------------------------------------------------------------------------
// Sequential list engine package
// Types, codes and default sizes shared by the list engine modules.
// ----------------------------------------------------------------------------
package sle_pkg;

	// Default sizes of the list.
	localparam int DEF_CAPACITY      = 64;
	localparam int DEF_ELEMENT_BYTES = 10;

	// Fixed field widths of the request and result channels.
	localparam int CMD_W    = 3;
	localparam int POS_W    = 7;
	localparam int ELEM_W   = 80;
	localparam int STATUS_W = 2;
	localparam int CNTO_W   = 7;

	// Command codes; code 7 is unused and is rejected.
	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 3'd0,
		CMD_DELETE = 3'd1,
		CMD_GET    = 3'd2,
		CMD_LOCATE = 3'd3,
		CMD_PREV   = 3'd4,
		CMD_NEXT   = 3'd5,
		CMD_CLEAR  = 3'd6
	} sle_cmd_t;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} sle_state_t;

	// Operation applied to every cell of the chain at once.
	typedef struct packed {
		logic rotate;
		logic insert;
		logic remove;
	} cell_op_t;

endpackage

[rtl/sequential_list_engine.sv]
// ----------------------------------------------------------------------------
// Sequential list engine
// Fixed-capacity ordered list of elements held in a ring of cells.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the s_ channel: tuser carries the command, tdata the
// one-based position and the element. Every request gives exactly one result
// on the m_ channel: status in tuser, returned element, located position,
// count and empty flag in tdata.
// Insert, clear and the unused command go from acceptance straight to the
// finishing step and then to the output register. Delete, get, locate,
// previous and next first scan the ring: it is rotated once, one entry
// passing the head cell per cycle, and the head is compared or captured as
// it goes by. Insert and delete then shift every cell at once.
// A new request is taken as soon as the previous one has reached the output
// register.
// Reset empties the list; cell contents need no clearing. While the receiver
// stalls, one result waits in the output register and the next request is
// worked up to its finishing step, where it holds until the register frees.
// ----------------------------------------------------------------------------
module sequential_list_engine import sle_pkg::*; #(
	parameter int CAPACITY      = DEF_CAPACITY,
	parameter int ELEMENT_BYTES = DEF_ELEMENT_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,  // position[6:0], element_low[70:7], element_high[86:71], zero
	input  logic [2:0]  s_tuser,  // command[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// found_low[63:0], found_high[79:64], found_position[86:80], count[93:87],
	// is_empty[94], zero[95]
	output logic [95:0] m_tdata,
	output logic [1:0]  m_tuser   // status[1:0]
);

	localparam int EB    = (ELEMENT_BYTES < 10) ? ELEMENT_BYTES : 10;
	localparam int EW    = EB * 8;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [EW-1:0]       element;
	logic [EW-1:0]       cell_q [CAPACITY];
	cell_op_t            cell_op;
	logic [IDX_W-1:0]    cell_idx;
	logic [EW-1:0]       cell_data;
	logic [STATUS_W-1:0] status;
	logic [ELEM_W-1:0]   found;
	logic [CNTO_W-1:0]   found_position;
	logic [CNTO_W-1:0]   count;
	logic                is_empty;

	// Bytes beyond the element size are dropped.
	assign element = EW'({s_tdata[86:71], s_tdata[70:7]});

	// Controller.
	sle_ctrl #(
		.CAPACITY (CAPACITY),
		.EW       (EW),
		.IDX_W    (IDX_W),
		.CNT_W    (CNT_W)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.command        (s_tuser),
		.position       (s_tdata[6:0]),
		.element        (element),
		.head           (cell_q[0]),
		.cell_op        (cell_op),
		.cell_idx       (cell_idx),
		.cell_data      (cell_data),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.status         (status),
		.found          (found),
		.found_position (found_position),
		.count          (count),
		.is_empty       (is_empty)
	);

	// Ring of cells; cell zero is the head seen by the controller.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		sle_cell #(
			.INDEX (i),
			.IDX_W (IDX_W),
			.EW    (EW)
		) u_cell (
			.clk      (clk),
			.op       (cell_op),
			.idx      (cell_idx),
			.new_data (cell_data),
			.left     (cell_q[(i + CAPACITY - 1) % CAPACITY]),
			.right    (cell_q[(i + 1) % CAPACITY]),
			.data_q   (cell_q[i])
		);
	end

	// Result packing.
	assign m_tuser = status;
	assign m_tdata = {1'b0, is_empty, count, found_position, found};

endmodule

[rtl/sle_cell.sv]
// ----------------------------------------------------------------------------
// List cell
// Holds one list entry and moves it to or from its neighbors on command.
// ----------------------------------------------------------------------------
module sle_cell import sle_pkg::*; #(
	parameter int INDEX = 0,
	parameter int IDX_W = 6,
	parameter int EW    = 80
) (
	input  logic             clk,
	input  cell_op_t         op,
	input  logic [IDX_W-1:0] idx,
	input  logic [EW-1:0]    new_data,
	input  logic [EW-1:0]    left,
	input  logic [EW-1:0]    right,
	output logic [EW-1:0]    data_q
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	// Rotation walks the ring toward cell zero; insert opens a gap at idx and
	// remove closes the gap at idx. Entries hold no reset value.
	always_ff @(posedge clk) begin
		if (op.rotate) begin
			data_q <= right;
		end else if (op.insert) begin
			if (MY_IDX == idx) begin
				data_q <= new_data;
			end else if (MY_IDX > idx) begin
				data_q <= left;
			end
		end else if (op.remove && (MY_IDX >= idx)) begin
			data_q <= right;
		end
	end

endmodule

[rtl/sle_ctrl.sv]
// ----------------------------------------------------------------------------
// List engine controller
// Takes requests, sequences the scan of the cell ring and builds results.
// ----------------------------------------------------------------------------
`include "sequential_list_engine_assert.svh"

module sle_ctrl import sle_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int EW       = 80,
	parameter int IDX_W    = 6,
	parameter int CNT_W    = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	// Request side
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [CMD_W-1:0]    command,
	input  logic [POS_W-1:0]    position,
	input  logic [EW-1:0]       element,
	// Cell ring
	input  logic [EW-1:0]       head,
	output cell_op_t            cell_op,
	output logic [IDX_W-1:0]    cell_idx,
	output logic [EW-1:0]       cell_data,
	// Result side
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [STATUS_W-1:0] status,
	output logic [ELEM_W-1:0]   found,
	output logic [CNTO_W-1:0]   found_position,
	output logic [CNTO_W-1:0]   count,
	output logic                is_empty
);

	localparam int CW = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	sle_state_t         state_q, state_d;
	sle_cmd_t           cmd_q;
	logic [POS_W-1:0]   pos_q;
	logic [EW-1:0]      elem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   step_q;
	logic [EW-1:0]      prev_q;
	logic [EW-1:0]      res_q;
	logic [CNT_W-1:0]   fpos_q;
	logic               found_q;
	logic               res_ok_q;
	logic               want_next_q;
	logic               out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [EW-1:0]      found_data_q;
	logic [CNT_W-1:0]   found_pos_q;
	logic [CNT_W-1:0]   count_q;

	logic               accept;
	logic               commit;
	logic               needs_scan;
	logic [CW-1:0]      pos_ext;
	logic [CW-1:0]      n_ext;
	logic [CW-1:0]      step_ext;
	logic [CW-1:0]      pos_m1;
	logic               pos_in_list;
	logic               pos_ins;
	logic               is_full;
	logic               in_list;
	logic               hit;
	logic               last_step;

	logic [STATUS_W-1:0] status_d;
	logic [EW-1:0]      found_d;
	logic [CNT_W-1:0]   fpos_d;
	logic [CNT_W-1:0]   cnt_d;
	logic               ins_go;
	logic               del_go;

	// Position and count checks, worked in a common width.
	assign pos_ext     = CW'(pos_q);
	assign n_ext       = CW'(cnt_q);
	assign step_ext    = CW'(step_q);
	assign pos_m1      = pos_ext - CW'(1);
	assign pos_in_list = (pos_ext != '0) && (pos_ext <= n_ext);
	assign pos_ins     = (pos_ext != '0) && (pos_ext <= n_ext + CW'(1));
	assign is_full     = (n_ext == CW'(CAPACITY));
	assign in_list     = (step_q < cnt_q);
	assign hit         = in_list && (head == elem_q) && !found_q;
	assign last_step   = (step_q == CNT_W'(CAPACITY - 1));

	assign accept = s_tvalid && s_tready;
	assign commit = (state_q == ST_FINISH) && (!out_valid_q || m_tready);

	// Commands that read entries need one full turn of the ring.
	always_comb begin
		unique case (sle_cmd_t'(command))
			CMD_DELETE, CMD_GET, CMD_LOCATE, CMD_PREV, CMD_NEXT: needs_scan = 1'b1;
			default: needs_scan = 1'b0;
		endcase
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = needs_scan ? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (last_step) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (commit) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs toward the request side and the cells.
	always_comb begin
		s_tready       = (state_q == ST_IDLE);
		cell_op.rotate = (state_q == ST_SCAN);
		cell_op.insert = commit && ins_go;
		cell_op.remove = commit && del_go;
		cell_idx       = IDX_W'(pos_m1);
		cell_data      = elem_q;
	end

	// Result of the command, valid in the finishing state.
	always_comb begin
		status_d = STAT_BAD;
		found_d  = '0;
		fpos_d   = '0;
		cnt_d    = cnt_q;
		ins_go   = 1'b0;
		del_go   = 1'b0;
		unique case (cmd_q)
			CMD_INSERT: begin
				if (pos_ins) begin
					if (is_full) begin
						status_d = STAT_FULL;
					end else begin
						status_d = STAT_OK;
						ins_go   = 1'b1;
						cnt_d    = cnt_q + CNT_W'(1);
					end
				end
			end
			CMD_DELETE: begin
				if (pos_in_list) begin
					status_d = STAT_OK;
					found_d  = res_q;
					del_go   = 1'b1;
					cnt_d    = cnt_q - CNT_W'(1);
				end
			end
			CMD_GET: begin
				if (pos_in_list) begin
					status_d = STAT_OK;
					found_d  = res_q;
				end
			end
			CMD_LOCATE: begin
				if (res_ok_q) begin
					status_d = STAT_OK;
					fpos_d   = fpos_q;
				end
			end
			CMD_PREV, CMD_NEXT: begin
				if (res_ok_q) begin
					status_d = STAT_OK;
					found_d  = res_q;
				end
			end
			CMD_CLEAR: begin
				status_d = STAT_OK;
				cnt_d    = '0;
			end
			default: status_d = STAT_BAD;
		endcase
	end

	// State, count and scan step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= '0;
			end else if (state_q == ST_SCAN) begin
				step_q <= step_q + CNT_W'(1);
			end
			if (commit) begin
				cnt_q <= cnt_d;
			end
		end
	end

	// Search flags of the running scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			res_ok_q    <= 1'b0;
			want_next_q <= 1'b0;
		end else if (accept) begin
			found_q     <= 1'b0;
			res_ok_q    <= 1'b0;
			want_next_q <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			if (hit) begin
				found_q <= 1'b1;
			end
			unique case (cmd_q)
				CMD_LOCATE: begin
					if (hit) begin
						res_ok_q <= 1'b1;
					end
				end
				CMD_PREV: begin
					if (hit && (step_q != '0)) begin
						res_ok_q <= 1'b1;
					end
				end
				CMD_NEXT: begin
					if (want_next_q && in_list) begin
						res_ok_q <= 1'b1;
					end
					want_next_q <= hit;
				end
				default: res_ok_q <= res_ok_q;
			endcase
		end
	end

	// Request payload and values picked off the head of the ring.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= sle_cmd_t'(command);
			pos_q  <= position;
			elem_q <= element;
			res_q  <= '0;
			fpos_q <= '0;
		end else if (state_q == ST_SCAN) begin
			prev_q <= head;
			unique case (cmd_q)
				CMD_DELETE, CMD_GET: begin
					if (step_ext == pos_m1) begin
						res_q <= head;
					end
				end
				CMD_LOCATE: begin
					if (hit) begin
						fpos_q <= step_q + CNT_W'(1);
					end
				end
				CMD_PREV: begin
					if (hit && (step_q != '0)) begin
						res_q <= prev_q;
					end
				end
				CMD_NEXT: begin
					if (want_next_q && in_list) begin
						res_q <= head;
					end
				end
				default: res_q <= res_q;
			endcase
		end
	end

	// Output register: the result waits here until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q     <= status_d;
			found_data_q <= found_d;
			found_pos_q  <= fpos_d;
			count_q      <= cnt_d;
		end
	end

	assign m_tvalid       = out_valid_q;
	assign status         = status_q;
	assign found          = ELEM_W'(found_data_q);
	assign found_position = CNTO_W'(found_pos_q);
	assign count          = CNTO_W'(count_q);
	assign is_empty       = (count_q == '0);

	// Checks on the sequencing.
	`SLE_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(CAPACITY))
	`SLE_ASSERT_IMP(a_scan_step, clk, arst_n, state_q == ST_SCAN, step_q < CNT_W'(CAPACITY))
	`SLE_ASSERT_NXT(a_accept_busy, clk, arst_n, accept, state_q != ST_IDLE)
	`SLE_ASSERT_IMP(a_valid_src, clk, arst_n, $rose(out_valid_q), $past(state_q) == ST_FINISH)

endmodule
